[rtl/core/wavhp_pkg.sv]
// Shared types, tag constants and status codes for the WAV header parser.
// No dependencies; imported by every module of the parser.
`timescale 1ns / 1ps

package wavhp_pkg;

	// Canonical header layout
	localparam int unsigned HDR_BYTES        = 44;
	localparam int unsigned FIRST_PART_BYTES = 36;
	localparam logic [31:0] FMT_SIZE_PCM     = 32'd16;
	localparam logic [15:0] PCM_FORMAT       = 16'd1;

	// Tags, first file byte in the top byte lane
	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_TAGS    = 3'd2,
		ST_FMT_SIZE    = 3'd3,
		ST_NOT_PCM     = 3'd4,
		ST_DATA_TAG    = 3'd5,
		ST_UNSUPPORTED = 3'd6
	} status_t;

	// Header capture state
	typedef struct packed {
		logic [5:0]  byte_index;
		logic        tags_ok;
		logic        data_tag_ok;
		logic [31:0] fmt_length;
		logic [15:0] format_code;
		logic [15:0] chan_count;
		logic [31:0] rate_reg;
		logic [15:0] sample_bits;
		logic [31:0] data_length;
	} hdr_state_t;

	localparam hdr_state_t HDR_RESET = '{
		byte_index:  6'd0,
		tags_ok:     1'b1,
		data_tag_ok: 1'b1,
		fmt_length:  32'd0,
		format_code: 16'd0,
		chan_count:  16'd0,
		rate_reg:    32'd0,
		sample_bits: 16'd0,
		data_length: 32'd0
	};

	// Result of the check stage
	typedef struct packed {
		logic        emit;
		status_t     status;
		logic [31:0] frames;
	} hdr_result_t;

	// Pick byte pos of a tag, pos 0 being the first byte in the file
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] pos);
		logic [7:0] b;
		unique case (pos)
			2'd0: b = tag[31:24];
			2'd1: b = tag[23:16];
			2'd2: b = tag[15:8];
			default: b = tag[7:0];
		endcase
		return b;
	endfunction

endpackage

[rtl/core/wavhp_capture.sv]
// Header byte capture: folds one file byte into the header state.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wavhp_capture (
	input  wavhp_pkg::hdr_state_t cur,
	input  logic [7:0]            byte_in,
	output wavhp_pkg::hdr_state_t nxt
);
	import wavhp_pkg::*;

	logic [5:0] idx;
	logic [1:0] pos;
	logic       active;

	assign idx    = cur.byte_index;
	assign pos    = idx[1:0];
	assign active = (idx != 6'(HDR_BYTES));

	// Compare tags and place field bytes little-endian
	always_comb begin
		nxt = cur;
		if (active) begin
			nxt.byte_index = idx + 6'd1;
			if (idx < 6'd4) begin
				if (byte_in != tag_byte(TAG_RIFF, pos)) nxt.tags_ok = 1'b0;
			end else if (idx >= 6'd8 && idx < 6'd12) begin
				if (byte_in != tag_byte(TAG_WAVE, pos)) nxt.tags_ok = 1'b0;
			end else if (idx >= 6'd12 && idx < 6'd16) begin
				if (byte_in != tag_byte(TAG_FMT, pos)) nxt.tags_ok = 1'b0;
			end else if (idx >= 6'd16 && idx < 6'd20) begin
				nxt.fmt_length[{pos, 3'b000} +: 8] = byte_in;
			end else if (idx >= 6'd20 && idx < 6'd22) begin
				nxt.format_code[{idx[0], 3'b000} +: 8] = byte_in;
			end else if (idx >= 6'd22 && idx < 6'd24) begin
				nxt.chan_count[{idx[0], 3'b000} +: 8] = byte_in;
			end else if (idx >= 6'd24 && idx < 6'd28) begin
				nxt.rate_reg[{pos, 3'b000} +: 8] = byte_in;
			end else if (idx >= 6'd34 && idx < 6'd36) begin
				nxt.sample_bits[{idx[0], 3'b000} +: 8] = byte_in;
			end else if (idx >= 6'd36 && idx < 6'd40) begin
				if (byte_in != tag_byte(TAG_DATA, pos)) nxt.data_tag_ok = 1'b0;
			end else if (idx >= 6'd40 && idx < 6'd44) begin
				nxt.data_length[{pos, 3'b000} +: 8] = byte_in;
			end
		end
	end

endmodule

[rtl/core/wavhp_check.sv]
// Header checks: decides whether a result is due, its status and frame count.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wavhp_check (
	input  wavhp_pkg::hdr_state_t  cur,
	input  wavhp_pkg::hdr_state_t  nxt,
	input  logic                   last_byte,
	output wavhp_pkg::hdr_result_t res
);
	import wavhp_pkg::*;

	logic    active;
	logic    full_hit;
	status_t first_st;
	status_t full_st;
	status_t short_st;
	logic    bits_ok;
	logic    chans_ok;
	logic [1:0] shift;

	assign active   = (cur.byte_index != 6'(HDR_BYTES));
	assign full_hit = active && (cur.byte_index == 6'(HDR_BYTES - 1));
	assign bits_ok  = (nxt.sample_bits == 16'd8) || (nxt.sample_bits == 16'd16);
	assign chans_ok = (nxt.chan_count == 16'd1) || (nxt.chan_count == 16'd2);

	// Status over bytes 0-35
	always_comb begin
		priority if (!nxt.tags_ok)                    first_st = ST_BAD_TAGS;
		else if (nxt.fmt_length != FMT_SIZE_PCM)      first_st = ST_FMT_SIZE;
		else if (nxt.format_code != PCM_FORMAT)       first_st = ST_NOT_PCM;
		else                                          first_st = ST_OK;
	end

	// Status for a complete header
	always_comb begin
		priority if (first_st != ST_OK)      full_st = first_st;
		else if (!nxt.data_tag_ok)           full_st = ST_DATA_TAG;
		else if (!bits_ok || !chans_ok)      full_st = ST_UNSUPPORTED;
		else                                 full_st = ST_OK;
	end

	// Status for a file that ends inside the header
	always_comb begin
		priority if (nxt.byte_index < 6'(FIRST_PART_BYTES)) short_st = ST_TOO_SHORT;
		else if (first_st != ST_OK)                         short_st = first_st;
		else                                                short_st = ST_TOO_SHORT;
	end

	// Frames: bytes per sample and channel count are each 1 or 2 when ok
	assign shift = {1'b0, nxt.sample_bits == 16'd16} + {1'b0, nxt.chan_count == 16'd2};

	always_comb begin
		res.emit   = active && (full_hit || last_byte);
		res.status = full_hit ? full_st : short_st;
		res.frames = (res.status == ST_OK) ? (nxt.data_length >> shift) : 32'd0;
	end

endmodule

[rtl/core/wav_header_parser_unit.sv]
// Top level of the WAV header parser: input register, header state, result register.
// Depends on wavhp_pkg, wavhp_capture and wavhp_check.
`timescale 1ns / 1ps

// Takes a WAV file one byte per transaction, last_byte set on its final byte,
// and returns exactly one result per file: after the 44th header byte, or at
// the last byte if the file ends sooner. Bytes past the header are dropped;
// the last byte rearms the parser for the next file. One byte is taken every
// cycle unless in_stall is raised; an accepted byte waits in the input register
// while the capture and check logic works on it ahead of the result register.
// A stall on the result side holds the input side only when both the result
// register and the input register are full.
module wav_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] channels,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_width,
	output logic [31:0] data_bytes,
	output logic [31:0] frame_count
);
	import wavhp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	hdr_state_t  hdr_q;
	hdr_state_t  hdr_nxt;
	hdr_result_t res;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] channels_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [31:0] data_q;
	logic [31:0] frames_q;

	// Stage moves on unless a result waits on a stalled output
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
			last_s1 <= last_byte;
		end
	end

	wavhp_capture u_capture (
		.cur     (hdr_q),
		.byte_in (byte_s1),
		.nxt     (hdr_nxt)
	);

	wavhp_check u_check (
		.cur       (hdr_q),
		.nxt       (hdr_nxt),
		.last_byte (last_s1),
		.res       (res)
	);

	// Header state; the last byte rearms it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= HDR_RESET;
		end else if (valid_s1 && advance) begin
			hdr_q <= last_s1 ? HDR_RESET : hdr_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.emit) begin
			status_q   <= res.status;
			channels_q <= hdr_nxt.chan_count;
			rate_q     <= hdr_nxt.rate_reg;
			bits_q     <= hdr_nxt.sample_bits;
			data_q     <= hdr_nxt.data_length;
			frames_q   <= res.frames;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign channels     = channels_q;
	assign rate_hz      = rate_q;
	assign sample_width = bits_q;
	assign data_bytes   = data_q;
	assign frame_count  = frames_q;

endmodule

[dv/tb_wav_header_parser_unit.sv]
// Self-checking testbench for wav_header_parser_unit: feeds WAV files byte by byte and
// compares every header report against a built-in header tracker.
// Depends on wavhp_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_wav_header_parser_unit;
	import wavhp_pkg::*;

	localparam int          NO_FLIP   = -1;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned LIMIT     = 400000;

	// One header report as the block presents it
	typedef struct packed {
		status_t     st;
		logic [15:0] ch;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] dlen;
		logic [31:0] frames;
	} hdr_report_t;

	// One file to send: header fields, total length, a byte to flip,
	// and optionally a typed-in status and frame count
	typedef struct packed {
		int unsigned len;
		logic [15:0] ch;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] dlen;
		logic [31:0] fsize;
		logic [15:0] fcode;
		int          bad_at;
		bit          typed;
		status_t     st;
		logic [31:0] frames;
	} wav_case_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] channels;
	logic [31:0] rate_hz;
	logic [15:0] sample_width;
	logic [31:0] data_bytes;
	logic [31:0] frame_count;

	hdr_report_t expected_hdrs[$];
	logic [7:0]  file_bytes[$];
	hdr_state_t  hdr_track = HDR_RESET;
	bit          hdr_sent = 1'b0;
	bit          row_typed = 1'b0;
	status_t     row_status;
	logic [31:0] row_frames;

	bit          calm = 1'b0;
	int unsigned holds_asked = 0;
	int unsigned holds_taken = 0;
	int unsigned hold_left = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned bytes_sent = 0;
	int unsigned files_sent = 0;

	// Directed files: truncation at the tag boundaries, each status, priorities, extremes
	wav_case_t dir_cases [16] = '{
		//   len  ch        rate          bits      dlen          fsize         fcode     flip
		'{   1,   1,        8000,         8,        100,          16,           1,        NO_FLIP,
			1'b1, ST_TOO_SHORT,   0},
		'{  35,   1,        8000,         8,        100,          16,           1,        NO_FLIP,
			1'b1, ST_TOO_SHORT,   0},
		'{  36,   2,        44100,        16,       0,            16,           1,        NO_FLIP,
			1'b1, ST_TOO_SHORT,   0},
		'{  36,   2,        44100,        16,       0,            17,           1,        NO_FLIP,
			1'b1, ST_FMT_SIZE,    0},
		'{  36,   1,        8000,         8,        100,          16,           1,        0,
			1'b1, ST_BAD_TAGS,    0},
		'{  43,   1,        8000,         8,        100,          16,           1,        37,
			1'b1, ST_TOO_SHORT,   0},
		'{  44,   1,        8000,         8,        100,          16,           1,        NO_FLIP,
			1'b1, ST_OK,          100},
		'{  44,   2,        32'hFFFFFFFF, 16,       32'hFFFFFFFF, 16,           1,        NO_FLIP,
			1'b0, ST_OK,          0},
		'{  46,   1,        22050,        16,       1000,         16,           1,        11,
			1'b1, ST_BAD_TAGS,    0},
		'{  36,   1,        22050,        16,       1000,         16,           16'hFFFF, NO_FLIP,
			1'b1, ST_NOT_PCM,     0},
		'{  44,   1,        22050,        16,       1000,         16,           0,        37,
			1'b1, ST_NOT_PCM,     0},
		'{  36,   1,        22050,        16,       1000,         17,           1,        3,
			1'b1, ST_BAD_TAGS,    0},
		'{  46,   2,        48000,        16,       4000,         16,           1,        39,
			1'b1, ST_DATA_TAG,    0},
		'{  44,   16'hFFFF, 48000,        16'hFFFF, 4000,         16,           1,        NO_FLIP,
			1'b1, ST_UNSUPPORTED, 0},
		'{  45,   2,        11025,        8,        1001,         16,           1,        NO_FLIP,
			1'b0, ST_OK,          0},
		'{  44,   1,        8000,         24,       100,          16,           1,        38,
			1'b1, ST_DATA_TAG,    0}
	};

	wav_header_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_in      (byte_in),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.channels     (channels),
		.rate_hz      (rate_hz),
		.sample_width (sample_width),
		.data_bytes   (data_bytes),
		.frame_count  (frame_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Byte k of a tag, k = 0 being the first byte in the file
	function automatic logic [7:0] tag_lane(input logic [31:0] tag, input int unsigned k);
		return tag[31 - 8*k -: 8];
	endfunction

	// Status from bytes 0-35 alone
	function automatic status_t head_code();
		if (!hdr_track.tags_ok) return ST_BAD_TAGS;
		if (hdr_track.fmt_length != FMT_SIZE_PCM) return ST_FMT_SIZE;
		if (hdr_track.format_code != PCM_FORMAT) return ST_NOT_PCM;
		return ST_OK;
	endfunction

	function automatic status_t full_code();
		status_t s;
		s = head_code();
		if (s != ST_OK) return s;
		if (!hdr_track.data_tag_ok) return ST_DATA_TAG;
		if (hdr_track.sample_bits != 16'd8 && hdr_track.sample_bits != 16'd16)
			return ST_UNSUPPORTED;
		if (hdr_track.chan_count != 16'd1 && hdr_track.chan_count != 16'd2)
			return ST_UNSUPPORTED;
		return ST_OK;
	endfunction

	function automatic status_t short_code();
		status_t s;
		if (hdr_track.byte_index < FIRST_PART_BYTES) return ST_TOO_SHORT;
		s = head_code();
		return (s != ST_OK) ? s : ST_TOO_SHORT;
	endfunction

	// Queue the report the block owes for the header tracked so far
	task automatic queue_report(input status_t s);
		hdr_report_t r;
		logic [15:0] per_sample;
		per_sample = hdr_track.sample_bits / 16'd8;
		r.st     = s;
		r.ch     = hdr_track.chan_count;
		r.rate   = hdr_track.rate_reg;
		r.bits   = hdr_track.sample_bits;
		r.dlen   = hdr_track.data_length;
		r.frames = '0;
		if (s == ST_OK && per_sample != 0 && hdr_track.chan_count != 0)
			r.frames = hdr_track.data_length / per_sample / hdr_track.chan_count;
		if (row_typed) begin
			r.st     = row_status;
			r.frames = row_frames;
		end
		expected_hdrs.push_back(r);
	endtask

	// Advance the header tracker by one accepted byte
	task automatic track_byte(input logic [7:0] b, input logic fin);
		int unsigned i;
		i = hdr_track.byte_index;
		if (!hdr_sent && i < HDR_BYTES) begin
			if (i < 4) begin
				if (b != tag_lane(TAG_RIFF, i)) hdr_track.tags_ok = 1'b0;
			end else if (i >= 8 && i < 12) begin
				if (b != tag_lane(TAG_WAVE, i - 8)) hdr_track.tags_ok = 1'b0;
			end else if (i >= 12 && i < 16) begin
				if (b != tag_lane(TAG_FMT, i - 12)) hdr_track.tags_ok = 1'b0;
			end else if (i >= 16 && i < 20) begin
				hdr_track.fmt_length[8*(i-16) +: 8] = b;
			end else if (i >= 20 && i < 22) begin
				hdr_track.format_code[8*(i-20) +: 8] = b;
			end else if (i >= 22 && i < 24) begin
				hdr_track.chan_count[8*(i-22) +: 8] = b;
			end else if (i >= 24 && i < 28) begin
				hdr_track.rate_reg[8*(i-24) +: 8] = b;
			end else if (i >= 34 && i < 36) begin
				hdr_track.sample_bits[8*(i-34) +: 8] = b;
			end else if (i >= 36 && i < 40) begin
				if (b != tag_lane(TAG_DATA, i - 36)) hdr_track.data_tag_ok = 1'b0;
			end else if (i >= 40) begin
				hdr_track.data_length[8*(i-40) +: 8] = b;
			end
			hdr_track.byte_index = 6'(i + 1);
			if (i + 1 == HDR_BYTES) begin
				queue_report(full_code());
				hdr_sent = 1'b1;
			end
		end
		// Last byte: report a short file, then rearm
		if (fin) begin
			if (!hdr_sent) queue_report(short_code());
			hdr_track = HDR_RESET;
			hdr_sent  = 1'b0;
		end
	endtask

	function automatic logic [7:0] hdr_byte(input wav_case_t c, input int unsigned i);
		if (i < 4) return tag_lane(TAG_RIFF, i);
		if (i < 8) return 8'($urandom);
		if (i < 12) return tag_lane(TAG_WAVE, i - 8);
		if (i < 16) return tag_lane(TAG_FMT, i - 12);
		if (i < 20) return c.fsize[8*(i-16) +: 8];
		if (i < 22) return c.fcode[8*(i-20) +: 8];
		if (i < 24) return c.ch[8*(i-22) +: 8];
		if (i < 28) return c.rate[8*(i-24) +: 8];
		if (i < 34) return 8'($urandom);
		if (i < 36) return c.bits[8*(i-34) +: 8];
		if (i < 40) return tag_lane(TAG_DATA, i - 36);
		return c.dlen[8*(i-40) +: 8];
	endfunction

	// Mostly well-formed headers with random content; some broken or cut short
	function automatic wav_case_t rand_case();
		wav_case_t   c;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			c.len = 44 + $urandom_range(0, 8);
		else if (pick < 9)
			c.len = $urandom_range(1, 43);
		else
			c.len = 44 + $urandom_range(9, 80);
		c.ch     = ($urandom_range(0, 7) != 0) ? 16'($urandom_range(1, 2)) : 16'($urandom);
		c.bits   = ($urandom_range(0, 7) != 0) ? ($urandom_range(0, 1) ? 16'd16 : 16'd8)
		                                       : 16'($urandom);
		c.rate   = $urandom;
		c.dlen   = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 64)) : $urandom;
		c.fsize  = ($urandom_range(0, 9) != 0) ? FMT_SIZE_PCM : $urandom;
		c.fcode  = ($urandom_range(0, 9) != 0) ? PCM_FORMAT : 16'($urandom);
		c.bad_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 43)) : NO_FLIP;
		c.typed  = 1'b0;
		c.st     = ST_OK;
		c.frames = '0;
		return c;
	endfunction

	task automatic make_file(input wav_case_t c);
		logic [7:0] b;
		file_bytes.delete();
		for (int unsigned i = 0; i < c.len; i++) begin
			b = (i < HDR_BYTES) ? hdr_byte(c, i) : 8'($urandom);
			if (int'(i) == c.bad_at) b ^= 8'h20;
			file_bytes.push_back(b);
		end
	endtask

	task automatic make_noise(input int unsigned n);
		file_bytes.delete();
		repeat (n) file_bytes.push_back(8'($urandom));
	endtask

	// Offer one byte and hold it until the transaction completes
	task automatic push_byte(input logic [7:0] b, input logic fin);
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		byte_in   <= b;
		last_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int unsigned i = 0; i < file_bytes.size(); i++)
			push_byte(file_bytes[i], i == file_bytes.size() - 1);
		files_sent++;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// Output side: random stall bursts, plus a long hold on request
	always @(posedge clk) begin
		if (holds_taken != holds_asked) begin
			holds_taken <= holds_taken + 1;
			hold_left   <= LONG_HOLD;
			out_stall   <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			out_stall  <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			burst_left <= $urandom_range(0, 6);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each delivered report with the oldest one owed
	always @(posedge clk) begin
		hdr_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (expected_hdrs.size() == 0) begin
				flag_mismatch("report with none owed, status", 32'(status), '0);
			end else begin
				want = expected_hdrs.pop_front();
				if (status !== want.st) flag_mismatch("status", 32'(status), 32'(want.st));
				if (channels !== want.ch) flag_mismatch("channels", 32'(channels), 32'(want.ch));
				if (rate_hz !== want.rate) flag_mismatch("rate_hz", rate_hz, want.rate);
				if (sample_width !== want.bits)
					flag_mismatch("sample_width", 32'(sample_width), 32'(want.bits));
				if (data_bytes !== want.dlen) flag_mismatch("data_bytes", data_bytes, want.dlen);
				if (frame_count !== want.frames)
					flag_mismatch("frame_count", frame_count, want.frames);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("[%0t] watchdog expired with %0d reports owed", $time, expected_hdrs.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned rand_files;
		int unsigned drain;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		byte_in   = 8'd0;
		last_byte = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed files
		foreach (dir_cases[k]) begin
			row_typed  = dir_cases[k].typed;
			row_status = dir_cases[k].st;
			row_frames = dir_cases[k].frames;
			make_file(dir_cases[k]);
			send_file();
		end
		row_typed = 1'b0;

		// Pause until every owed report is out
		in_valid <= 1'b0;
		while (expected_hdrs.size() != 0) @(posedge clk);

		// Long output hold while tiny files keep coming, so the input backs up
		holds_asked <= holds_asked + 1;
		while (hold_left == 0) @(posedge clk);
		repeat (12) begin
			make_noise($urandom_range(1, 3));
			send_file();
		end

		// Random files, a tenth of them pure noise
		rand_files = 0;
		while (rand_files < 4) begin
			if ($urandom_range(0, 9) == 0)
				make_noise($urandom_range(1, 50));
			else
				make_file(rand_case());
			send_file();
			rand_files++;
		end

		// Closing stretch at full rate on both sides
		calm <= 1'b1;
		repeat (2) begin
			make_file(rand_case());
			send_file();
		end
		in_valid <= 1'b0;

		drain = 0;
		while (expected_hdrs.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (expected_hdrs.size() != 0)
			flag_mismatch("header reports never arrived", 32'(expected_hdrs.size()), '0);

		$display("Sent %0d files (%0d bytes) and compared %0d header reports, %0d mismatches.",
			files_sent, bytes_sent, results_checked, mismatches);
		$display("Covered every status code, cuts at the tag boundaries, noise and a long hold.");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/wavhp_pkg.sv
rtl/core/wavhp_capture.sv
rtl/core/wavhp_check.sv
rtl/core/wav_header_parser_unit.sv
dv/tb_wav_header_parser_unit.sv
